### design/mcg_pkg.sv
// Shared types and constants for the midpoint circle generator.
package mcg_pkg;

	localparam int COORD_WIDTH = 10;
	localparam int DEC_WIDTH   = COORD_WIDTH + 2;
	localparam int PIX_WIDTH   = 12;
	localparam int COLOR_WIDTH = 4;
	localparam int IDX_WIDTH   = 3;

	localparam logic [COLOR_WIDTH-1:0] COLOR_RESET = COLOR_WIDTH'(15);
	localparam logic [IDX_WIDTH-1:0]   IDX_LAST    = IDX_WIDTH'(7);

	localparam logic [DEC_WIDTH-1:0] DEC_START     = DEC_WIDTH'(1);
	localparam logic [DEC_WIDTH-1:0] DEC_INC_SIDE  = DEC_WIDTH'(3);
	localparam logic [DEC_WIDTH-1:0] DEC_INC_DIAG  = DEC_WIDTH'(5);

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [9:0] center_x;
		logic [9:0] center_y;
		logic [8:0] radius;
	} in_word_t;

	typedef struct packed {
		logic signed [PIX_WIDTH-1:0] pixel_x;
		logic signed [PIX_WIDTH-1:0] pixel_y;
		logic [COLOR_WIDTH-1:0]      color;
		logic                        last;
	} out_word_t;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] cx;
		logic [COORD_WIDTH-1:0] cy;
		logic [COORD_WIDTH-1:0] x;
		logic [COORD_WIDTH-1:0] y;
		logic                   last;
	} point_t;

endpackage

### design/midpoint_circle_generator.sv
// Midpoint circle rasteriser with eight-way symmetric pixel output.
// Each input word is taken on a handshake: a start loads the centre and radius, a step runs
// one midpoint iteration, and either one yields eight pixel words, one per cycle from the
// output register while out_ready holds. A step while no circle is active yields nothing.
// One computed point waits in a holding register while the previous point is still being
// sent, so the input is taken again as soon as the emitter takes the held point.
module midpoint_circle_generator
	import mcg_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_word_t               in_word,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_word_t              out_word,
	input  logic                   cfg_we,
	input  logic [COLOR_WIDTH-1:0] cfg_wdata
);

	logic [COLOR_WIDTH-1:0] color_q;
	logic [COORD_WIDTH-1:0] cx_q, cy_q, oct_x_q, oct_y_q;
	logic [DEC_WIDTH-1:0]   dec_q;
	logic                   active_q;

	point_t                 pend_s1;
	logic                   pend_v_s1;
	point_t                 pt_s2;
	logic                   busy_s2;
	logic [IDX_WIDTH-1:0]   idx_q;
	logic                   out_valid_q;
	out_word_t              out_q;

	logic                   accept, advance, take, emit;
	logic [COORD_WIDTH-1:0] r_c, x_nxt, y_nxt, cx_nxt, cy_nxt;
	logic [DEC_WIDTH-1:0]   x_d, y_d, dec_inc, dec_nxt;
	logic                   active_nxt;

	logic                   swap, xneg, yneg;
	logic [COORD_WIDTH-1:0] dx, dy;
	logic [PIX_WIDTH-1:0]   px, py;

	assign advance  = !out_valid_q || out_ready;
	assign take     = pend_v_s1 && (!busy_s2 || (advance && idx_q == IDX_LAST));
	assign in_ready = !pend_v_s1 || take;
	assign accept   = in_valid && in_ready;

	// next circle state
	always_comb begin
		r_c     = COORD_WIDTH'(in_word.radius);
		x_d     = DEC_WIDTH'(oct_x_q);
		y_d     = DEC_WIDTH'(oct_y_q);
		if (dec_q[DEC_WIDTH-1]) begin
			dec_inc = (x_d << 1) + DEC_INC_SIDE;
		end else begin
			dec_inc = ((x_d - y_d) << 1) + DEC_INC_DIAG;
		end
		if (in_word.mode == MODE_START) begin
			cx_nxt     = COORD_WIDTH'(in_word.center_x);
			cy_nxt     = COORD_WIDTH'(in_word.center_y);
			x_nxt      = '0;
			y_nxt      = r_c;
			dec_nxt    = DEC_START - DEC_WIDTH'(r_c);
			active_nxt = (r_c != '0);
			emit       = 1'b1;
		end else begin
			cx_nxt     = cx_q;
			cy_nxt     = cy_q;
			x_nxt      = oct_x_q + COORD_WIDTH'(1);
			y_nxt      = dec_q[DEC_WIDTH-1] ? oct_y_q : oct_y_q - COORD_WIDTH'(1);
			dec_nxt    = dec_q + dec_inc;
			active_nxt = (x_nxt < y_nxt);
			emit       = active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q  <= COLOR_RESET;
			cx_q     <= '0;
			cy_q     <= '0;
			oct_x_q  <= '0;
			oct_y_q  <= '0;
			dec_q    <= '0;
			active_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			if (accept && emit) begin
				cx_q     <= cx_nxt;
				cy_q     <= cy_nxt;
				oct_x_q  <= x_nxt;
				oct_y_q  <= y_nxt;
				dec_q    <= dec_nxt;
				active_q <= active_nxt;
			end
		end
	end

	// hold the next point while the current one drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_s1 <= 1'b0;
		end else if (accept && emit) begin
			pend_v_s1 <= 1'b1;
		end else if (take) begin
			pend_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			pend_s1.cx   <= cx_nxt;
			pend_s1.cy   <= cy_nxt;
			pend_s1.x    <= x_nxt;
			pend_s1.y    <= y_nxt;
			pend_s1.last <= !active_nxt;
		end
		if (take) begin
			pt_s2 <= pend_s1;
		end
	end

	// mirror the point into the octant picked by the index
	always_comb begin
		swap = idx_q[0] ^ idx_q[1];
		xneg = idx_q[2];
		yneg = !(idx_q[1] ^ idx_q[2]);
		dx   = swap ? pt_s2.y : pt_s2.x;
		dy   = swap ? pt_s2.x : pt_s2.y;
		px   = xneg ? PIX_WIDTH'(pt_s2.cx) - PIX_WIDTH'(dx) : PIX_WIDTH'(pt_s2.cx) + PIX_WIDTH'(dx);
		py   = yneg ? PIX_WIDTH'(pt_s2.cy) - PIX_WIDTH'(dy) : PIX_WIDTH'(pt_s2.cy) + PIX_WIDTH'(dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s2     <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_s2;
			end
			if (take) begin
				busy_s2 <= 1'b1;
				idx_q   <= '0;
			end else if (advance && busy_s2) begin
				idx_q <= idx_q + IDX_WIDTH'(1);
				if (idx_q == IDX_LAST) begin
					busy_s2 <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && busy_s2) begin
			out_q.pixel_x <= px;
			out_q.pixel_y <= py;
			out_q.color   <= color_q;
			out_q.last    <= pt_s2.last && (idx_q == IDX_LAST);
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_pend_taken: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_s1 && !busy_s2 |=> busy_s2)
		else $error("held point not moved to the emitter");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s2 && idx_q != '0 |-> out_valid_q)
		else $error("emission under way without an output word");

	a_active_order: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> oct_x_q < oct_y_q)
		else $error("active circle with x not below y");

	a_start_active: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_word.mode == MODE_START && COORD_WIDTH'(in_word.radius) != '0
		|=> active_q)
		else $error("start with nonzero radius left the circle idle");

	a_last_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.last |-> !active_q || pend_v_s1 || busy_s2)
		else $error("last word flagged while circle still running");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the midpoint circle generator against an in-bench rasteriser.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mcg_pkg::*;

	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_PRINTS     = 40;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	in_word_t               in_word;
	logic                   out_valid;
	logic                   out_ready;
	out_word_t              out_word;
	logic                   cfg_we;
	logic [COLOR_WIDTH-1:0] cfg_wdata;

	logic [COORD_WIDTH-1:0]      circ_cx;
	logic [COORD_WIDTH-1:0]      circ_cy;
	logic [COORD_WIDTH-1:0]      circ_x;
	logic [COORD_WIDTH-1:0]      circ_y;
	logic signed [DEC_WIDTH-1:0] circ_dec;
	bit                          circ_active;
	logic [COLOR_WIDTH-1:0]      circ_colour;

	out_word_t pending_pixels[$];
	int        emitting_words;
	int        errors;
	int        idle_run;
	int        burst_left;
	bit        tx_gaps;
	bit        hold_req;
	rx_mode_e  rx_mode;

	midpoint_circle_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= MAX_PRINTS) begin
			$display("%0t: %s got %0h expected %0h", $time, what, got, want);
		end
	endtask

	function automatic void push_octants(bit last);
		int        cx, cy, x, y;
		int        px[8];
		int        py[8];
		out_word_t pix;
		cx = int'(circ_cx);
		cy = int'(circ_cy);
		x  = int'(circ_x);
		y  = int'(circ_y);
		px = '{cx + x, cx + y, cx + y, cx + x, cx - x, cx - y, cx - y, cx - x};
		py = '{cy - y, cy - x, cy + x, cy + y, cy + y, cy + x, cy - x, cy - y};
		for (int k = 0; k < 8; k++) begin
			pix.pixel_x = PIX_WIDTH'(px[k]);
			pix.pixel_y = PIX_WIDTH'(py[k]);
			pix.color   = circ_colour;
			pix.last    = last && (k == 7);
			pending_pixels.push_back(pix);
		end
	endfunction

	function automatic void rasterise_word(input in_word_t w);
		int x, y, p;
		if (w.mode == MODE_START) begin
			circ_cx     = w.center_x;
			circ_cy     = w.center_y;
			circ_x      = '0;
			circ_y      = COORD_WIDTH'(w.radius);
			circ_dec    = DEC_WIDTH'(int'(DEC_START) - int'(w.radius));
			circ_active = (w.radius != 0);
		end else if (circ_active) begin
			x = int'(circ_x);
			y = int'(circ_y);
			p = int'(circ_dec);
			if (p < 0) begin
				p += 2 * x + int'(DEC_INC_SIDE);
			end else begin
				p += 2 * (x - y) + int'(DEC_INC_DIAG);
				y--;
			end
			x++;
			circ_dec    = DEC_WIDTH'(p);
			circ_x      = COORD_WIDTH'(x);
			circ_y      = COORD_WIDTH'(y);
			circ_active = (circ_x < circ_y);
		end else begin
			return;
		end
		emitting_words++;
		push_octants(!circ_active);
	endfunction

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected pixel word", 32'(out_word), '0);
			end else begin
				want = pending_pixels.pop_front();
				if (out_word.pixel_x !== want.pixel_x)
					report_mismatch("pixel_x", 32'(out_word.pixel_x), 32'(want.pixel_x));
				if (out_word.pixel_y !== want.pixel_y)
					report_mismatch("pixel_y", 32'(out_word.pixel_y), 32'(want.pixel_y));
				if (out_word.color !== want.color)
					report_mismatch("color", 32'(out_word.color), 32'(want.color));
				if (out_word.last !== want.last)
					report_mismatch("last", 32'(out_word.last), 32'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_run <= 0;
		end else begin
			idle_run <= idle_run + 1;
			if (idle_run >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		phase     = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			phase++;
			if (hold_req) begin
				hold_req  = 1'b0;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			case (rx_mode)
				RX_ALWAYS:  out_ready = 1'b1;
				RX_RANDOM:  out_ready = ($urandom_range(0, 3) != 0);
				RX_PATTERN: out_ready = !((phase % 5 == 3) || (phase % 7 == 0));
				default:    out_ready = ($urandom_range(0, 4) < 2);
			endcase
		end
	end

	task automatic send_word(input in_word_t w);
		if (tx_gaps) begin
			if (burst_left == 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_word  = w;
		do @(posedge clk); while (!in_ready);
		rasterise_word(w);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_colour(input logic [COLOR_WIDTH-1:0] c);
		wait_drained();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = c;
		@(negedge clk);
		cfg_we      = 1'b0;
		circ_colour = c;
	endtask

	function automatic in_word_t start_word(int cx, int cy, int r);
		in_word_t w;
		w.mode     = MODE_START;
		w.center_x = cx[9:0];
		w.center_y = cy[9:0];
		w.radius   = r[8:0];
		return w;
	endfunction

	function automatic in_word_t step_word();
		in_word_t w;
		w.mode     = MODE_STEP;
		w.center_x = 10'($urandom_range(0, 1023));
		w.center_y = 10'($urandom_range(0, 1023));
		w.radius   = 9'($urandom_range(0, 511));
		return w;
	endfunction

	function automatic int pick_radius();
		int n;
		n = $urandom_range(0, 99);
		if (n < 70) return $urandom_range(0, 24);
		if (n < 90) return $urandom_range(25, 80);
		if (n < 98) return $urandom_range(81, 300);
		return $urandom_range(301, 511);
	endfunction

	task automatic run_circle(input in_word_t s, input int max_steps, input int extra);
		int k;
		k = 0;
		send_word(s);
		while (circ_active && k < max_steps) begin
			send_word(step_word());
			k++;
		end
		repeat (extra) send_word(step_word());
	endtask

	task automatic test_idle_steps();
		tx_gaps = 1'b0;
		rx_mode = RX_ALWAYS;
		send_word(in_word_t'{MODE_STEP, 10'h3ff, 10'h3ff, 9'h1ff});
		send_word(in_word_t'{MODE_STEP, 10'h000, 10'h000, 9'h000});
		send_word(step_word());
	endtask

	task automatic test_small_radius();
		rx_mode = RX_PATTERN;
		run_circle(start_word(0, 0, 0), 0, 1);
		run_circle(start_word(1023, 1023, 0), 0, 0);
		run_circle(start_word(0, 0, 1), 10, 1);
		run_circle(start_word(1023, 0, 2), 10, 0);
	endtask

	task automatic test_extreme_centres();
		set_colour(4'd0);
		tx_gaps = 1'b1;
		rx_mode = RX_RANDOM;
		run_circle(start_word(0, 1023, 511), 3, 0);
		run_circle(start_word(1023, 0, 511), 3, 0);
		run_circle(start_word(512, 511, 3), 10, 0);
	endtask

	task automatic test_backpressure();
		set_colour(4'hA);
		tx_gaps  = 1'b0;
		rx_mode  = RX_ALWAYS;
		hold_req = 1'b1;
		run_circle(start_word($urandom_range(0, 1023), $urandom_range(0, 1023), 30), 24, 0);
	endtask

	task automatic test_drain_pause();
		set_colour(COLOR_WIDTH'($urandom_range(0, 15)));
		tx_gaps = 1'b1;
		rx_mode = RX_SPARSE;
		send_word(start_word($urandom_range(0, 1023), $urandom_range(0, 1023), 40));
		repeat (8) send_word(step_word());
		wait_drained();
		repeat (8) send_word(step_word());
		wait_drained();
		run_circle(step_word(), 15, 1);
	endtask

	task automatic test_random_circles(input int budget, input rx_mode_e m, input bit gaps,
			input logic [COLOR_WIDTH-1:0] c);
		int       target, r, max_steps;
		in_word_t w;
		set_colour(c);
		rx_mode = m;
		tx_gaps = gaps;
		target  = emitting_words + budget;
		while (emitting_words < target) begin
			if ($urandom_range(0, 99) < 85) begin
				r = pick_radius();
				if (r > 80)
					max_steps = $urandom_range(1, 30);
				else if ($urandom_range(0, 3) == 0)
					max_steps = $urandom_range(0, r);
				else
					max_steps = 1000;
				run_circle(start_word($urandom_range(0, 1023), $urandom_range(0, 1023), r),
					max_steps, $urandom_range(0, 2));
			end else begin
				w        = step_word();
				w.mode   = 1'($urandom_range(0, 1));
				send_word(w);
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_word     = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		circ_colour = COLOR_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_steps();
		test_small_radius();
		test_extreme_centres();
		test_backpressure();
		test_drain_pause();
		test_random_circles(65, RX_RANDOM, 1'b1, COLOR_WIDTH'($urandom_range(0, 15)));
		test_random_circles(65, RX_ALWAYS, 1'b0, 4'd15);
		test_random_circles(65, RX_PATTERN, 1'b1, COLOR_WIDTH'($urandom_range(0, 15)));

		wait_drained();
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### sim.f
design/mcg_pkg.sv
design/midpoint_circle_generator.sv
tb/sv/testbench.sv
